// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; btas_controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/btas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btas_pkg;

	localparam int LIST_BITS = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic setup;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_pick;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/btas_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module btas_datapath (
	input  wire              clk,
	input  btas_pkg::cmd_t    cmd,
	output btas_pkg::status_t status,
	input  wire              pre_index,
	input  wire              increment,
	input  wire              status_bit,
	input  wire              writeback,
	input  wire              load,
	input  wire [3:0]        base_reg,
	input  wire [15:0]       reg_list,
	input  wire [31:0]       base_value,
	output logic             transfer_valid,
	output logic [3:0]       reg_index,
	output logic [31:0]      address,
	output logic             is_load,
	output logic             align_pc,
	output logic             writeback_valid,
	output logic [3:0]       writeback_reg,
	output logic [31:0]      writeback_value,
	output logic             restore_status,
	output logic             last
);
	import btas_pkg::*;

	localparam logic [IDX_W-1:0] PC_INDEX = 4'd15;

	logic                 pre_q, up_q, sbit_q, wb_q, ld_q, pc_listed_q;
	logic [IDX_W-1:0]     breg_q;
	logic [LIST_BITS-1:0] rem_q;
	logic [ADDR_W-1:0]    base_q, addr_q, wval_q;
	logic [CNT_W-1:0]     count_q;

	logic [CNT_W-1:0]     count_d;
	logic [ADDR_W-1:0]    span;
	logic [IDX_W-1:0]     pick_idx;
	logic                 rem_zero;
	logic [LIST_BITS-1:0] rem_next;

	// Count listed registers.
	always_comb begin
		count_d = '0;
		for (int i = 0; i < LIST_BITS; i++) begin
			count_d = count_d + CNT_W'(reg_list[i]);
		end
	end

	// Lowest remaining register.
	always_comb begin
		pick_idx = '0;
		for (int i = LIST_BITS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick_idx = IDX_W'(i);
			end
		end
	end

	assign span     = {{(ADDR_W - CNT_W - 2){1'b0}}, count_q, 2'b00};
	assign rem_zero = (rem_q == '0);
	assign rem_next = rem_q & (rem_q - LIST_BITS'(1));

	assign status.final_pick = (rem_next == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pre_q       <= pre_index;
			up_q        <= increment;
			sbit_q      <= status_bit;
			wb_q        <= writeback;
			ld_q        <= load;
			breg_q      <= base_reg;
			rem_q       <= reg_list;
			pc_listed_q <= reg_list[PC_INDEX];
			base_q      <= base_value;
			count_q     <= count_d;
		end else if (cmd.setup) begin
			if (up_q) begin
				addr_q <= pre_q ? base_q + 32'd4 : base_q;
				wval_q <= base_q + span;
			end else begin
				addr_q <= pre_q ? base_q - span : base_q - span + 32'd4;
				wval_q <= base_q - span;
			end
		end else if (cmd.emit) begin
			rem_q  <= rem_next;
			addr_q <= addr_q + 32'd4;
		end
	end

	// Output register: load one result per emit.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			writeback_reg   <= status.final_pick ? breg_q : '0;
			writeback_valid <= status.final_pick ? wb_q : 1'b0;
			writeback_value <= status.final_pick ? wval_q : '0;
			last            <= status.final_pick;
			if (rem_zero) begin
				transfer_valid <= 1'b0;
				reg_index      <= '0;
				address        <= '0;
				is_load        <= 1'b0;
				align_pc       <= 1'b0;
				restore_status <= 1'b0;
			end else begin
				transfer_valid <= 1'b1;
				reg_index      <= pick_idx;
				address        <= addr_q;
				is_load        <= ld_q;
				align_pc       <= ld_q && (pick_idx == PC_INDEX);
				restore_status <= status.final_pick && ld_q && sbit_q && pc_listed_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/btas_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btas_controller (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	output btas_pkg::cmd_t    cmd,
	input  btas_pkg::status_t status
);
	import btas_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT:  if (out_free && status.final_pick) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		cmd.load_item = 1'b0;
		cmd.setup     = 1'b0;
		cmd.emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_EMIT:  cmd.emit  = out_free;
			default:  in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_accept_setup, clk, arst_n, in_valid && !in_stall, state_q == ST_SETUP, "accepted transaction did not enter setup")
	`ASSERT_NEXT(a_setup_emit, clk, arst_n, state_q == ST_SETUP, state_q == ST_EMIT, "setup did not advance to emit")
	`ASSERT_AT(a_no_overwrite, clk, arst_n, !cmd.emit || !out_valid_q || !out_stall, "held result overwritten")

endmodule

`default_nettype wire

// ===== rtl/block_transfer_address_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Block-transfer address sequencer: takes one decoded load/store-multiple
// transaction with its base register value and emits one result per listed
// register, lowest register first, at word addresses rising by 4 from the start
// address of the chosen mode (increment/decrement, before/after). The last
// result carries the base writeback and the status-restore flag; an empty list
// gives a single result with transfer_valid low. Sequence: a transaction is
// accepted, its addresses are set up, then max(n,1) results follow at one per
// cycle, while the output is not stalled, into a single output register. The
// rate is set by that output register, which takes one result per cycle unless
// out_stall holds a valid result in it. in_stall stays high after acceptance
// until the last result is loaded into the output register.
module block_transfer_address_sequencer_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        pre_index,
	input  wire        increment,
	input  wire        status_bit,
	input  wire        writeback,
	input  wire        load,
	input  wire [3:0]  base_reg,
	input  wire [15:0] reg_list,
	input  wire [31:0] base_value,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       transfer_valid,
	output logic [3:0] reg_index,
	output logic [31:0] address,
	output logic       is_load,
	output logic       align_pc,
	output logic       writeback_valid,
	output logic [3:0] writeback_reg,
	output logic [31:0] writeback_value,
	output logic       restore_status,
	output logic       last
);
	import btas_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence the transaction: accept, set up addresses, emit results.
	btas_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Hold the transaction, walk the register list, and drive the result fields.
	btas_datapath u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.status          (status),
		.pre_index       (pre_index),
		.increment       (increment),
		.status_bit      (status_bit),
		.writeback       (writeback),
		.load            (load),
		.base_reg        (base_reg),
		.reg_list        (reg_list),
		.base_value      (base_value),
		.transfer_valid  (transfer_valid),
		.reg_index       (reg_index),
		.address         (address),
		.is_load         (is_load),
		.align_pc        (align_pc),
		.writeback_valid (writeback_valid),
		.writeback_reg   (writeback_reg),
		.writeback_value (writeback_value),
		.restore_status  (restore_status),
		.last            (last)
	);

endmodule

`default_nettype wire
